/* hw/rtl/tone_segment_extractor_unit_defines.svh */
// Assertion macros shared by the tone segment extractor RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef TONE_SEGMENT_EXTRACTOR_UNIT_DEFINES_SVH
`define TONE_SEGMENT_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge outside reset.
`define TSE_ASSERT(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Same-cycle implication.
`define TSE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TSE_ASSERT(lbl, clk, rstn, cond, msg)
`define TSE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* hw/rtl/tse_pkg.sv */
`timescale 1ns / 1ps

package tse_pkg;

    // Field widths.
    localparam int unsigned TS_W    = 48;
    localparam int unsigned FREQ_W  = 25;
    localparam int unsigned DUR_W   = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Scaling from seconds to milliseconds.
    localparam int unsigned MS_SCALE_W = 10;
    localparam logic [MS_SCALE_W-1:0] MS_PER_S = 10'd1000;

    // Divider: the dividend is a segment length times 1000, which needs TS_W + 10 bits.
    localparam int unsigned DIVD_W = TS_W + MS_SCALE_W;
    localparam int unsigned STEP_W = $clog2(DIVD_W + 1);

    // Saturation limits of the result fields.
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [DUR_W-1:0]  DUR_MAX  = '1;

    // Register reset values.
    localparam logic [CFG_W-1:0] TOLERANCE_RESET = 16'd20;
    localparam logic [CFG_W-1:0] MIN_FREQ_RESET  = 16'd50;
    localparam logic [CFG_W-1:0] MIN_DUR_RESET   = 16'd100;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE = 2'd0,
        CFG_MIN_FREQ  = 2'd1,
        CFG_MIN_DUR   = 2'd2
    } t_cfg_idx;

    // Result kinds.
    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_SONG = 1'b1;

    // Current register contents.
    typedef struct packed {
        logic [CFG_W-1:0] tolerance_hz;
        logic [CFG_W-1:0] min_frequency_hz;
        logic [CFG_W-1:0] min_duration_ms;
    } t_cfg;

    // Divider command and status.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

/* hw/rtl/tse_ifs.sv */
`timescale 1ns / 1ps

// Edge item channel.
interface tse_in_if;
    logic                      valid;
    logic                      ready;
    logic [tse_pkg::TS_W-1:0]  timestamp_ticks;
    logic                      level;

    modport source (output valid, output timestamp_ticks, output level, input ready);
    modport sink   (input valid, input timestamp_ticks, input level, output ready);
endinterface

// Result item channel.
interface tse_out_if;
    logic                        valid;
    logic                        ready;
    logic                        event_kind;
    logic [tse_pkg::FREQ_W-1:0]  frequency_hz;
    logic [tse_pkg::DUR_W-1:0]   duration_ms;

    modport source (output valid, output event_kind, output frequency_hz,
                    output duration_ms, input ready);
    modport sink   (input valid, input event_kind, input frequency_hz,
                    input duration_ms, output ready);
endinterface

// Register write channel.
interface tse_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tse_pkg::CFG_IDX_W-1:0] index;
    logic [tse_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/tone_segment_extractor_unit.sv */
`timescale 1ns / 1ps
`include "tone_segment_extractor_unit_defines.svh"

// Channel  Port   Direction  Item contents
// edges    i_in   sink       timestamp_ticks[47:0], level
// results  o_out  source     event_kind, frequency_hz[24:0], duration_ms[31:0]
// config   i_cfg  sink       index[1:0], data[15:0]
//
// A low edge is taken while i_in.ready stays high.
// A high edge holds i_in.ready low through S_CALC, S_MUL, S_FDIV (a division of TW quotient bits,
// TW being the bit width of TICK_RATE) and S_FCHK, and through S_OUT when it produces a new-song marker.
// A finished note adds S_MDIV, which forms 58 quotient bits for the duration, and S_OUT to take them.
// A waiting result stalls the input only when the next high edge also yields a result.
// Reset is synchronous; it clears the edge and segment history and reloads the registers.
module tone_segment_extractor_unit #(
    parameter int unsigned TICK_RATE = 24000000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tse_in_if.sink      i_in,
    tse_out_if.source   o_out,
    tse_cfg_if.sink     i_cfg
);

    localparam int unsigned TW   = $clog2(TICK_RATE + 1);
    localparam int unsigned MP_W = tse_pkg::CFG_W + TW;
    localparam logic [tse_pkg::DIVD_W-1:0] TR_ALIGNED =
        tse_pkg::DIVD_W'(TICK_RATE) << (tse_pkg::DIVD_W - TW);
    localparam logic [tse_pkg::TS_W-1:0]   TR_DIVISOR = tse_pkg::TS_W'(TICK_RATE);
    localparam logic [tse_pkg::STEP_W-1:0] FREQ_STEPS = tse_pkg::STEP_W'(TW);
    localparam logic [tse_pkg::STEP_W-1:0] DUR_STEPS  = tse_pkg::STEP_W'(tse_pkg::DIVD_W);
    localparam logic [tse_pkg::FREQ_W-1:0] ZERO_GAP_FREQ =
        (TICK_RATE > (2 ** tse_pkg::FREQ_W - 1)) ? tse_pkg::FREQ_MAX
                                                 : tse_pkg::FREQ_W'(TICK_RATE);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CALC = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_FDIV = 7'b0001000,
        S_FCHK = 7'b0010000,
        S_MDIV = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Architectural history.
    logic [tse_pkg::TS_W-1:0]   r_prev_edge;
    logic [tse_pkg::FREQ_W-1:0] r_prev_freq;
    logic [tse_pkg::TS_W-1:0]   r_seg_start;

    // Working registers for the item in flight.
    logic [tse_pkg::TS_W-1:0]   r_ts;
    logic [tse_pkg::TS_W-1:0]   r_gap;
    logic [tse_pkg::TS_W-1:0]   r_seg;
    logic [MP_W-1:0]            r_min_prod;
    logic [tse_pkg::DIVD_W-1:0] r_scaled;
    logic [tse_pkg::FREQ_W-1:0] r_freq;
    logic                       r_res_kind;
    logic [tse_pkg::FREQ_W-1:0] r_res_freq;
    logic [tse_pkg::DUR_W-1:0]  r_res_dur;

    // Output register.
    logic                       r_out_valid;
    logic                       r_o_kind;
    logic [tse_pkg::FREQ_W-1:0] r_o_freq;
    logic [tse_pkg::DUR_W-1:0]  r_o_dur;

    tse_pkg::t_cfg              cfg;
    tse_pkg::t_div_ctl          div_ctl;
    tse_pkg::t_div_sts          div_sts;
    logic [tse_pkg::DIVD_W-1:0] div_dividend;
    logic [tse_pkg::TS_W-1:0]   div_divisor;
    logic [tse_pkg::DIVD_W-1:0] div_quot;

    logic                       in_fire;
    logic                       out_fire;
    logic                       out_free;
    logic [tse_pkg::FREQ_W-1:0] freq_diff;
    logic                       seg_break;
    logic                       long_enough;
    logic                       note_ok;
    logic                       song_ok;
    logic                       freq_start;
    logic                       dur_start;

    tse_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_sts      (div_sts),
        .o_quotient (div_quot)
    );

    // Handshakes.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid & i_in.ready;
    assign out_fire   = r_out_valid & o_out.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // Segment decision, taken in S_FCHK from registered values.
    assign freq_diff   = (r_freq > r_prev_freq) ? (r_freq - r_prev_freq)
                                                : (r_prev_freq - r_freq);
    assign seg_break   = freq_diff > tse_pkg::FREQ_W'(cfg.tolerance_hz);
    assign long_enough = r_scaled > tse_pkg::DIVD_W'(r_min_prod);
    assign note_ok     = (r_prev_freq > tse_pkg::FREQ_W'(cfg.min_frequency_hz)) && long_enough;
    assign song_ok     = r_prev_freq < tse_pkg::FREQ_W'(cfg.min_frequency_hz);

    // Divider sharing: frequency first, then the note duration when needed.
    assign freq_start    = (r_state == S_MUL);
    assign dur_start     = (r_state == S_FCHK) && seg_break && note_ok;
    assign div_ctl.start = freq_start || dur_start;
    assign div_ctl.steps = freq_start ? FREQ_STEPS : DUR_STEPS;
    assign div_dividend  = freq_start ? TR_ALIGNED : r_scaled;
    assign div_divisor   = freq_start ? r_gap : TR_DIVISOR;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_in.level) n_state = S_CALC;
            end
            S_CALC: n_state = S_MUL;
            S_MUL:  n_state = S_FDIV;
            S_FDIV: begin
                if (div_sts.done) n_state = S_FCHK;
            end
            S_FCHK: begin
                if (seg_break && note_ok) begin
                    n_state = S_MDIV;
                end else if (seg_break && song_ok) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MDIV: begin
                if (div_sts.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and history registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_edge <= '0;
            r_prev_freq <= '0;
            r_seg_start <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire && !i_in.level) begin
                r_prev_edge <= i_in.timestamp_ticks;
            end
            if (r_state == S_CALC) begin
                r_prev_edge <= r_ts;
            end
            if (r_state == S_FCHK) begin
                r_prev_freq <= r_freq;
                if (seg_break) r_seg_start <= r_ts;
            end
            if (out_fire) r_out_valid <= 1'b0;
            if ((r_state == S_OUT) && out_free) r_out_valid <= 1'b1;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ts <= i_in.timestamp_ticks;
        end
        if (r_state == S_CALC) begin
            r_gap      <= r_ts - r_prev_edge;
            r_seg      <= r_ts - r_seg_start;
            r_min_prod <= MP_W'(cfg.min_duration_ms) * MP_W'(TICK_RATE);
        end
        if (r_state == S_MUL) begin
            r_scaled <= tse_pkg::DIVD_W'(r_seg) * tse_pkg::DIVD_W'(tse_pkg::MS_PER_S);
        end
        if ((r_state == S_FDIV) && div_sts.done) begin
            if (r_gap == '0) begin
                r_freq <= ZERO_GAP_FREQ;
            end else if (div_quot > tse_pkg::DIVD_W'(tse_pkg::FREQ_MAX)) begin
                r_freq <= tse_pkg::FREQ_MAX;
            end else begin
                r_freq <= div_quot[tse_pkg::FREQ_W-1:0];
            end
        end
        if (r_state == S_FCHK) begin
            // The outgoing note carries the frequency of the segment that ended.
            r_res_kind <= note_ok ? tse_pkg::KIND_NOTE : tse_pkg::KIND_SONG;
            r_res_freq <= note_ok ? r_prev_freq : '0;
            r_res_dur  <= '0;
        end
        if ((r_state == S_MDIV) && div_sts.done) begin
            r_res_dur <= (div_quot > tse_pkg::DIVD_W'(tse_pkg::DUR_MAX))
                         ? tse_pkg::DUR_MAX : div_quot[tse_pkg::DUR_W-1:0];
        end
        if ((r_state == S_OUT) && out_free) begin
            r_o_kind <= r_res_kind;
            r_o_freq <= r_res_freq;
            r_o_dur  <= r_res_dur;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_o_kind;
    assign o_out.frequency_hz = r_o_freq;
    assign o_out.duration_ms  = r_o_dur;

    `TSE_ASSERT(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "sequencer state not one-hot")
    `TSE_ASSERT_IMP(a_div_done_expected, i_clk, i_rst_n, div_sts.done, (r_state == S_FDIV) || (r_state == S_MDIV), "divider finished while no division was awaited")
    `TSE_ASSERT_IMP(a_div_busy_awaited, i_clk, i_rst_n, ((r_state == S_FDIV) || (r_state == S_MDIV)) && !div_sts.done, div_sts.busy, "division awaited while the divider is idle")
    `TSE_ASSERT_IMP(a_marker_blank, i_clk, i_rst_n, o_out.valid && (o_out.event_kind == tse_pkg::KIND_SONG), (o_out.frequency_hz == '0) && (o_out.duration_ms == '0), "new-song marker carries a frequency or duration")
    `TSE_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_OUT) && out_free, r_out_valid && (r_state == S_IDLE), "finished result not placed in the output register")

endmodule

/* hw/rtl/tse_cfg.sv */
`timescale 1ns / 1ps

// Configuration registers, written one at a time through the write channel.
module tse_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tse_cfg_if.sink       i_cfg,
    output tse_pkg::t_cfg o_cfg
);

    tse_pkg::t_cfg r_cfg;
    logic          wr_fire;

    // Writes are always taken; an index past the list is dropped.
    assign i_cfg.ready = 1'b1;
    assign wr_fire     = i_cfg.valid & i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance_hz     <= tse_pkg::TOLERANCE_RESET;
            r_cfg.min_frequency_hz <= tse_pkg::MIN_FREQ_RESET;
            r_cfg.min_duration_ms  <= tse_pkg::MIN_DUR_RESET;
        end else if (wr_fire) begin
            case (i_cfg.index)
                tse_pkg::CFG_TOLERANCE: r_cfg.tolerance_hz     <= i_cfg.data;
                tse_pkg::CFG_MIN_FREQ:  r_cfg.min_frequency_hz <= i_cfg.data;
                tse_pkg::CFG_MIN_DUR:   r_cfg.min_duration_ms  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/tse_div.sv */
`timescale 1ns / 1ps
`include "tone_segment_extractor_unit_defines.svh"

// Bit-serial restoring divider. The dividend sits left-aligned in a shift
// register; each cycle one bit moves into the partial remainder and one
// quotient bit moves in at the bottom. After the requested number of steps
// the quotient fills the low bits of the same register.
module tse_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tse_pkg::t_div_ctl            i_ctl,
    input  logic [tse_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [tse_pkg::TS_W-1:0]     i_divisor,
    output tse_pkg::t_div_sts            o_sts,
    output logic [tse_pkg::DIVD_W-1:0]   o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [tse_pkg::STEP_W-1:0]    r_cnt;
    logic [tse_pkg::DIVD_W-1:0]    r_q;
    logic [tse_pkg::TS_W-1:0]      r_rem;
    logic [tse_pkg::TS_W-1:0]      r_div;

    logic [tse_pkg::TS_W:0]        trial;
    logic [tse_pkg::TS_W:0]        diff;
    logic                          fits;

    // One trial subtraction per cycle.
    assign trial = {r_rem, r_q[tse_pkg::DIVD_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    // Control: step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - tse_pkg::STEP_W'(1);
                if (r_cnt == tse_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data path: remainder and dividend/quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[tse_pkg::DIVD_W-2:0], fits};
            r_rem <= fits ? diff[tse_pkg::TS_W-1:0] : trial[tse_pkg::TS_W-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_q;

    `TSE_ASSERT_IMP(a_div_no_restart, i_clk, i_rst_n, i_ctl.start, !r_busy, "divider restarted while busy")
    `TSE_ASSERT_IMP(a_div_done_follows_busy, i_clk, i_rst_n, r_done, $past(r_busy) && !r_busy, "divider done without a preceding step")
    `TSE_ASSERT_IMP(a_div_count_live, i_clk, i_rst_n, r_busy, r_cnt != '0, "divider busy with no steps left")

endmodule
